/* sv/assert_macros.svh */
// shared assertion macros for the nanosecond clock block
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked on every rising edge out of reset
`define MNCL_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("mncl: same-cycle check failed");

// next-cycle implication, checked on every rising edge out of reset
`define MNCL_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("mncl: next-cycle check failed");

`endif

/* sv/mncl_pkg.sv */
// ----------------------------------------------------------------------------
// mncl_pkg
// shared widths, constants, state and control types of the nanosecond clock
// ----------------------------------------------------------------------------
package mncl_pkg;

    localparam int WORD_W    = 64;
    localparam int HZ_W      = 34;
    localparam int RES_W     = 20;
    localparam int SCALE_W   = 30;
    localparam int CNT_W     = 6;
    localparam int CFG_IDX_W = 2;

    localparam logic [WORD_W-1:0]  NS_PER_S     = 64'd1000000000;
    localparam logic [WORD_W-1:0]  NS_PER_MS    = 64'd1000000;
    localparam logic [SCALE_W-1:0] SCALE_NS     = 30'd1000000000;
    localparam logic [SCALE_W-1:0] RES_CAP_WIDE = 30'd1000000;
    localparam logic [RES_W-1:0]   RES_CAP      = 20'd1000000;
    localparam logic [RES_W-1:0]   RES_FLOOR    = 20'd1;

    localparam logic [CNT_W-1:0] DIV_LAST  = CNT_W'(WORD_W - 1);
    localparam logic [CNT_W-1:0] FRAC_LAST = CNT_W'(SCALE_W - 1);

    localparam logic [CFG_IDX_W-1:0] CFG_HZ   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BASE = 2'd1;

    typedef enum logic [1:0] {
        S_IDLE,
        S_DIV,
        S_FRAC,
        S_DONE
    } mncl_state_t;

    // per-unit control from the sequencer
    typedef struct packed {
        logic load;
        logic step;
        logic tick;
    } mncl_step_t;

endpackage

/* sv/mncl_long_div.sv */
// ----------------------------------------------------------------------------
// mncl_long_div
// bit-serial divider: whole seconds scaled to ns, or ms ticks scaled to ns
// ----------------------------------------------------------------------------
module mncl_long_div
    import mncl_pkg::*;
(
    input  logic              clk,
    input  mncl_step_t        ctrl,
    input  logic [WORD_W-1:0] dividend,
    input  logic [HZ_W-1:0]   divisor,
    output logic [WORD_W-1:0] acc,
    output logic [HZ_W-1:0]   rem
);

    logic [WORD_W-1:0] shift_reg, shift_next;
    logic [HZ_W-1:0]   rem_reg, rem_next;
    logic [WORD_W-1:0] acc_reg, acc_next;

    logic            top_bit;
    logic [HZ_W:0]   trial;
    logic [HZ_W:0]   trial_sub;
    logic            ge;
    logic            qbit;
    logic [WORD_W-1:0] addend;

    always_comb
    begin
        top_bit   = shift_reg[WORD_W-1];
        trial     = {rem_reg, top_bit};
        trial_sub = trial - {1'b0, divisor};
        ge        = (trial >= {1'b0, divisor});
        // in tick mode the reading bits themselves drive the scaling
        qbit      = ctrl.tick ? top_bit : ge;
        addend    = ctrl.tick ? NS_PER_MS : NS_PER_S;

        shift_next = shift_reg;
        rem_next   = rem_reg;
        acc_next   = acc_reg;
        if (ctrl.load)
        begin
            shift_next = dividend;
            rem_next   = '0;
            acc_next   = '0;
        end
        else if (ctrl.step)
        begin
            shift_next = {shift_reg[WORD_W-2:0], 1'b0};
            rem_next   = ge ? trial_sub[HZ_W-1:0] : trial[HZ_W-1:0];
            acc_next   = {acc_reg[WORD_W-2:0], 1'b0} + (qbit ? addend : '0);
        end
    end

    always_ff @(posedge clk)
    begin
        shift_reg <= shift_next;
        rem_reg   <= rem_next;
        acc_reg   <= acc_next;
    end

    assign acc = acc_reg;
    assign rem = rem_reg;

endmodule

/* sv/mncl_frac.sv */
// ----------------------------------------------------------------------------
// mncl_frac
// bit-serial scaled fraction (rem * 1e9 / hz) and step size (1e9 / hz)
// ----------------------------------------------------------------------------
module mncl_frac
    import mncl_pkg::*;
(
    input  logic               clk,
    input  mncl_step_t         ctrl,
    input  logic [HZ_W-1:0]    part,
    input  logic [HZ_W-1:0]    divisor,
    output logic [SCALE_W-1:0] frac,
    output logic [SCALE_W-1:0] res_q
);

    logic [SCALE_W-1:0] scale_reg, scale_next;
    logic [SCALE_W-1:0] fq_reg, fq_next;
    logic [HZ_W-1:0]    fr_reg, fr_next;
    logic [SCALE_W-1:0] rq_reg, rq_next;
    logic [HZ_W-1:0]    rr_reg, rr_next;

    logic              sbit;
    logic [HZ_W+1:0]   t;
    logic [HZ_W+1:0]   d1;
    logic [HZ_W+1:0]   d2;
    logic [HZ_W+1:0]   t_sub;
    logic [1:0]        k;
    logic [HZ_W:0]     rt;
    logic [HZ_W:0]     rt_sub;
    logic              rge;

    always_comb
    begin
        sbit = scale_reg[SCALE_W-1];
        // value = 2 * value + bit * part, kept as quotient and remainder
        t    = {1'b0, fr_reg, 1'b0} + (sbit ? {2'b00, part} : '0);
        d1   = {2'b00, divisor};
        d2   = {1'b0, divisor, 1'b0};
        if (t >= d2)
        begin
            t_sub = t - d2;
            k     = 2'd2;
        end
        else if (t >= d1)
        begin
            t_sub = t - d1;
            k     = 2'd1;
        end
        else
        begin
            t_sub = t;
            k     = 2'd0;
        end

        // step size: same recurrence with a unit multiplicand
        rt     = {rr_reg, sbit};
        rt_sub = rt - {1'b0, divisor};
        rge    = (rt >= {1'b0, divisor});

        scale_next = scale_reg;
        fq_next    = fq_reg;
        fr_next    = fr_reg;
        rq_next    = rq_reg;
        rr_next    = rr_reg;
        if (ctrl.load)
        begin
            scale_next = SCALE_NS;
            fq_next    = '0;
            fr_next    = '0;
            rq_next    = '0;
            rr_next    = '0;
        end
        // the fraction unit idles in tick mode
        else if (ctrl.step && !ctrl.tick)
        begin
            scale_next = {scale_reg[SCALE_W-2:0], 1'b0};
            fq_next    = {fq_reg[SCALE_W-2:0], 1'b0} + {{(SCALE_W-2){1'b0}}, k};
            fr_next    = t_sub[HZ_W-1:0];
            rq_next    = {rq_reg[SCALE_W-2:0], rge};
            rr_next    = rge ? rt_sub[HZ_W-1:0] : rt[HZ_W-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        scale_reg <= scale_next;
        fq_reg    <= fq_next;
        fr_reg    <= fr_next;
        rq_reg    <= rq_next;
        rr_reg    <= rr_next;
    end

    assign frac  = fq_reg;
    assign res_q = rq_reg;

endmodule

/* sv/monotonic_ns_clock_core.sv */
// ----------------------------------------------------------------------------
// monotonic_ns_clock_core
// Turns raw counter readings into a monotonic nanosecond clock. Each word in
// is one reading; each word out carries now_ns, held_back and resolution_ns.
// With counter_hz nonzero the reading less counter_base (mod 2^64) is split
// into whole seconds and a remainder by a one-bit-per-cycle divider, then
// the remainder is scaled by 1e9 and divided by counter_hz in a second
// serial unit (one bit of 1e9 per cycle), which also produces the step size
// 1e9 / counter_hz. In millisecond tick mode (counter_hz zero) the reading
// is scaled by 1e6 through the first unit alone. The output register lets
// the next reading be taken while a result waits; a result that would not
// move past the last value returned is held back and flagged instead.
// Configuration writes are taken at any time but are only meant while the
// block is idle.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module monotonic_ns_clock_core
    import mncl_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,

    // configuration write port
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [WORD_W-1:0]    cfg_data,

    // reading in
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [WORD_W-1:0]    reading,

    // time word out
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [WORD_W-1:0]    now_ns,
    output logic                 held_back,
    output logic [RES_W-1:0]     resolution_ns
);

    // configuration registers
    logic [HZ_W-1:0]   hz_reg;
    logic [WORD_W-1:0] base_reg;

    // sequencer
    mncl_state_t       state_reg, state_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;

    // monotonic state
    logic [WORD_W-1:0] last_reg, last_next;

    // output register
    logic              out_valid_reg, out_valid_next;
    logic [WORD_W-1:0] now_reg;
    logic              held_reg;
    logic [RES_W-1:0]  res_reg;

    mncl_step_t        div_ctrl;
    mncl_step_t        frac_ctrl;
    logic              tick_mode;
    logic              accept;
    logic              out_free;
    logic              out_load;

    logic [WORD_W-1:0]  dividend;
    logic [WORD_W-1:0]  whole_ns;
    logic [HZ_W-1:0]    part;
    logic [SCALE_W-1:0] frac;
    logic [SCALE_W-1:0] res_q;

    logic [WORD_W-1:0] fresh;
    logic [WORD_W-1:0] diff;
    logic              ahead;
    logic [RES_W-1:0]  res_val;

    // zero frequency selects millisecond ticks
    assign tick_mode = (hz_reg == '0);
    assign accept    = in_valid && in_ready;
    assign out_free  = !out_valid_reg || out_ready;

    // --------------------------------------------------------------------
    // configuration decode
    // --------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hz_reg   <= '0;
            base_reg <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_HZ:   hz_reg   <= cfg_data[HZ_W-1:0];
                CFG_BASE: base_reg <= cfg_data;
                default:  ;
            endcase
        end
    end

    // counter mode works on the offset from the start value
    assign dividend = tick_mode ? reading : (reading - base_reg);

    // --------------------------------------------------------------------
    // serial units
    // --------------------------------------------------------------------
    mncl_long_div u_long_div
    (
        .clk      (clk),
        .ctrl     (div_ctrl),
        .dividend (dividend),
        .divisor  (hz_reg),
        .acc      (whole_ns),
        .rem      (part)
    );

    mncl_frac u_frac
    (
        .clk     (clk),
        .ctrl    (frac_ctrl),
        .part    (part),
        .divisor (hz_reg),
        .frac    (frac),
        .res_q   (res_q)
    );

    // --------------------------------------------------------------------
    // sequencer
    // --------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        in_ready       = 1'b0;
        out_load       = 1'b0;
        div_ctrl.load  = 1'b0;
        div_ctrl.step  = 1'b0;
        div_ctrl.tick  = tick_mode;
        frac_ctrl.load = 1'b0;
        frac_ctrl.step = 1'b0;
        frac_ctrl.tick = tick_mode;

        unique case (state_reg)
            S_IDLE:
            begin
                // a waiting result does not block the next reading
                in_ready = 1'b1;
                if (in_valid)
                begin
                    div_ctrl.load  = 1'b1;
                    frac_ctrl.load = 1'b1;
                    cnt_next       = '0;
                    state_next     = S_DIV;
                end
            end
            S_DIV:
            begin
                div_ctrl.step = 1'b1;
                if (cnt_reg == DIV_LAST)
                begin
                    cnt_next   = '0;
                    state_next = tick_mode ? S_DONE : S_FRAC;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            S_FRAC:
            begin
                frac_ctrl.step = 1'b1;
                if (cnt_reg == FRAC_LAST)
                begin
                    cnt_next   = '0;
                    state_next = S_DONE;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            S_DONE:
            begin
                // wait here until the output register is free
                if (out_free)
                begin
                    out_load   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // --------------------------------------------------------------------
    // result assembly and monotonic clamp
    // --------------------------------------------------------------------
    always_comb
    begin
        fresh = whole_ns + (tick_mode ? '0 : {{(WORD_W-SCALE_W){1'b0}}, frac});
        diff  = fresh - last_reg;
        // strictly ahead as a signed 64-bit difference
        ahead = (diff != '0) && !diff[WORD_W-1];

        if (tick_mode)
            res_val = RES_CAP;
        else if (res_q == '0)
            res_val = RES_FLOOR;
        else if (res_q > RES_CAP_WIDE)
            res_val = RES_CAP;
        else
            res_val = res_q[RES_W-1:0];

        last_next = last_reg;
        if (out_load && ahead)
            last_next = fresh;

        out_valid_next = out_valid_reg;
        if (out_load)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            last_reg      <= last_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            now_reg  <= ahead ? fresh : last_reg;
            held_reg <= !ahead;
            res_reg  <= res_val;
        end
    end

    assign out_valid     = out_valid_reg;
    assign now_ns        = now_reg;
    assign held_back     = held_reg;
    assign resolution_ns = res_reg;

    // --------------------------------------------------------------------
    // checks
    // --------------------------------------------------------------------
    // the last value only moves when a result is handed to the output
    `MNCL_ASSERT_NEXT(a_last_only_on_done, clk, rst_n, state_reg != S_DONE, $stable(last_reg))
    // a waiting word always shows the stored last value
    `MNCL_ASSERT_NOW(a_out_is_last, clk, rst_n, out_valid_reg, now_reg == last_reg)
    // tick mode skips the fraction unit
    `MNCL_ASSERT_NOW(a_frac_counter_only, clk, rst_n, state_reg == S_FRAC, !tick_mode)
    // an accepted reading starts the divider
    `MNCL_ASSERT_NEXT(a_accept_starts, clk, rst_n, accept, state_reg == S_DIV && cnt_reg == '0)

endmodule
